### rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and sizes for the sorted table search block.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int LEN_W       = 6;
   localparam int VALUE_W     = 32;
   localparam int BOUND_W     = LEN_W + 1;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_LINEAR = 2'd1,
      ACT_BINARY = 2'd2
   } action_type;

   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic [LEN_W-1:0]           len_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic signed [BOUND_W-1:0]  bound_type;

endpackage

### rtl/sorted_table_search.sv
// ----------------------------------------------------------------------------
// sorted_table_search
// Table of signed entries with linear and binary search over the first
// table_length entries (at most 32), in one single-port synchronous memory.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          carries
//   req_     in         valid / stall      action, entry index/value, key
//   rsp_     out        valid / stall      found, position, final bounds
//   csr_     in         write enable only  table_length
//
// A load writes its entry when accepted and gives no transaction on rsp_.
// A linear search over n entries issues one memory read per cycle and
// compares each registered read result while the next read is issued.
// A binary search runs each probe as a read (ST_PROBE), then a compare
// (ST_CHECK) on the registered read data from the single memory read port.
// Synchronous active-high reset clears control state; table contents are
// undefined until loaded. A stalled result waits in the output register.

module sorted_table_search (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_action,
   input  sts_pkg::addr_type    req_entry_index,
   input  sts_pkg::value_type   req_entry_value,
   input  sts_pkg::value_type   req_search_key,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output sts_pkg::addr_type    rsp_position,
   output sts_pkg::len_type     rsp_final_lower,
   output logic signed [5:0]    rsp_final_upper,
   input  logic                 csr_wr_en,
   input  sts_pkg::len_type     csr_wr_data
);

   import sts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PROBE,
      ST_CHECK,
      ST_DONE
   } state_type;

   // control registers
   state_type  state_ff,    state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       pend_ff,     pend_in;
   len_type    len_ff,      len_in;

   // datapath registers
   value_type  key_ff,      key_in;
   len_type    cur_ff,      cur_in;
   len_type    n_ff,        n_in;
   addr_type   pend_idx_ff, pend_idx_in;
   addr_type   mid_ff,      mid_in;
   bound_type  lo_ff,       lo_in;
   bound_type  hi_ff,       hi_in;
   logic       mode_ff,     mode_in;
   logic       found_ff,    found_in;
   addr_type   pos_ff,      pos_in;

   logic               rsp_found_ff,  rsp_found_in;
   addr_type           rsp_pos_ff,    rsp_pos_in;
   len_type            rsp_lower_ff,  rsp_lower_in;
   logic signed [5:0]  rsp_upper_ff,  rsp_upper_in;

   // memory
   value_type  mem [TABLE_DEPTH];
   value_type  rd_data_ff;
   logic       mem_we;
   logic       mem_re;
   addr_type   rd_addr;

   logic               req_take;
   len_type            len_used;
   logic signed [7:0]  mid_sum;
   len_type            mid_full;
   logic               out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign len_used  = (len_ff > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : len_ff;
   assign mid_sum   = 8'(lo_ff) + 8'(hi_ff);
   assign mid_full  = mid_sum[6:1];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pend_in      = pend_ff;
      len_in       = csr_wr_en ? csr_wr_data : len_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      n_in         = n_ff;
      pend_idx_in  = pend_idx_ff;
      mid_in       = mid_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mode_in      = mode_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_lower_in = rsp_lower_ff;
      rsp_upper_in = rsp_upper_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      rd_addr      = cur_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               key_in   = req_search_key;
               found_in = 1'b0;
               pos_in   = '0;
               case (req_action)
                  ACT_LOAD: begin
                     mem_we = 1'b1;
                  end
                  ACT_LINEAR: begin
                     cur_in   = '0;
                     n_in     = len_used;
                     pend_in  = 1'b0;
                     mode_in  = 1'b0;
                     state_in = ST_SCAN;
                  end
                  ACT_BINARY: begin
                     lo_in    = '0;
                     hi_in    = $signed({1'b0, len_used}) - 7'sd1;
                     mode_in  = 1'b1;
                     state_in = ST_PROBE;
                  end
                  default: begin
                     // drop the unused action
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (pend_ff && rd_data_ff == key_ff) begin
               found_in = 1'b1;
               pos_in   = pend_idx_ff;
               pend_in  = 1'b0;
               state_in = ST_DONE;
            end else if (cur_ff < n_ff) begin
               // issue the next read while the previous compare runs
               mem_re      = 1'b1;
               rd_addr     = cur_ff[ADDR_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = cur_ff[ADDR_W-1:0];
               cur_in      = cur_ff + LEN_W'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_PROBE: begin
            if (lo_ff <= hi_ff) begin
               mem_re   = 1'b1;
               rd_addr  = mid_full[ADDR_W-1:0];
               mid_in   = mid_full[ADDR_W-1:0];
               state_in = ST_CHECK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CHECK: begin
            if (rd_data_ff == key_ff) begin
               found_in = 1'b1;
               pos_in   = mid_ff;
               state_in = ST_DONE;
            end else if (key_ff < rd_data_ff) begin
               hi_in    = $signed({2'b00, mid_ff}) - 7'sd1;
               state_in = ST_PROBE;
            end else begin
               lo_in    = $signed({2'b00, mid_ff}) + 7'sd1;
               state_in = ST_PROBE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_pos_in   = pos_ff;
               rsp_lower_in = mode_ff ? lo_ff[5:0] : '0;
               rsp_upper_in = mode_ff ? hi_ff[5:0] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         len_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      cur_ff       <= cur_in;
      n_ff         <= n_in;
      pend_idx_ff  <= pend_idx_in;
      mid_ff       <= mid_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mode_ff      <= mode_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_lower_ff <= rsp_lower_in;
      rsp_upper_ff <= rsp_upper_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req_entry_index] <= req_entry_value;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_final_lower = rsp_lower_ff;
   assign rsp_final_upper = rsp_upper_ff;

   a_check_after_probe: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> $past(state_ff) == ST_PROBE)
      else $error("compare state entered without a probe read");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result presented without a finished search");

   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE |-> lo_ff <= hi_ff + 7'sd1)
      else $error("binary search bounds crossed by more than one");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == ST_SCAN)
      else $error("pending scan read outside a linear search");

endmodule

### bench/sorted_table_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_search_checker
// Watches the request, result and register ports of the table search block.
// It keeps its own copy of the table and of table_length and works out the
// result of every accepted search. Each result is then compared, field by
// field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sorted_table_search_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_action,
   input  sts_pkg::addr_type    req_entry_index,
   input  sts_pkg::value_type   req_entry_value,
   input  sts_pkg::value_type   req_search_key,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_found,
   input  sts_pkg::addr_type    rsp_position,
   input  sts_pkg::len_type     rsp_final_lower,
   input  logic signed [5:0]    rsp_final_upper,
   input  logic                 csr_wr_en,
   input  sts_pkg::len_type     csr_wr_data,
   output int                   error_count,
   output int                   pending_count,
   output int                   checked_count
);
   import sts_pkg::*;

   typedef struct packed {
      logic               found;
      addr_type           position;
      len_type            lower;
      logic signed [5:0]  upper;
   } search_result_type;

   value_type           table_mem [TABLE_DEPTH];
   len_type             table_length;
   search_result_type   outstanding_results [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
      checked_count = 0;
      table_length  = '0;
      foreach (table_mem[i]) table_mem[i] = '0;
   end

   // Result of a linear or binary search over the table as it stands now.
   function automatic search_result_type search_table(logic [1:0] act, value_type key);
      search_result_type r;
      int n;
      int i;
      int lo;
      int hi;
      int mid;
      r = '0;
      n = (int'(table_length) > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_length);
      if (act == ACT_LINEAR) begin
         for (i = 0; i < n && !r.found; i++) begin
            if (table_mem[i] == key) begin
               r.found    = 1'b1;
               r.position = i[ADDR_W-1:0];
            end
         end
      end else begin
         lo = 0;
         hi = n - 1;
         while (lo <= hi && !r.found) begin
            mid = (lo + hi) / 2;
            if (table_mem[mid] == key) begin
               r.found    = 1'b1;
               r.position = mid[ADDR_W-1:0];
            end else if (key < table_mem[mid]) begin
               hi = mid - 1;
            end else begin
               lo = mid + 1;
            end
         end
         r.lower = lo[LEN_W-1:0];
         r.upper = hi[5:0];
      end
      return r;
   endfunction

   task automatic report_field(string name, int want, int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      search_result_type want;
      if (!reset) begin
         // Results first: a search cannot complete at the edge it is accepted.
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (outstanding_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual found=%0d pos=%0d",
                        $time, rsp_found, rsp_position);
            end else begin
               want = outstanding_results.pop_front();
               report_field("found", want.found, rsp_found);
               report_field("position", want.position, rsp_position);
               report_field("final_lower", want.lower, rsp_final_lower);
               report_field("final_upper", want.upper, rsp_final_upper);
            end
         end
         if (csr_wr_en) table_length = csr_wr_data;
         if (req_valid && !req_stall) begin
            case (req_action)
               ACT_LOAD:   table_mem[req_entry_index] = req_entry_value;
               ACT_LINEAR,
               ACT_BINARY: outstanding_results.push_back(search_table(req_action,
                                                                      req_search_key));
               default: ;
            endcase
         end
      end
      pending_count = outstanding_results.size();
   end

endmodule

### bench/sorted_table_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_search_tb
// Loads sorted tables of signed entries, sweeps table_length across its range
// and issues linear and binary searches with keys that hit, miss narrowly or
// land anywhere, under random gaps and stalls on both channels. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_table_search_tb;
   import sts_pkg::*;

   localparam logic [1:0] ACT_UNUSED    = 2'd3;
   localparam value_type  VALUE_MIN     = 32'sh8000_0000;
   localparam value_type  VALUE_MAX     = 32'sh7FFF_FFFF;
   localparam int         MAX_GAP       = 14;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         SETTLE_CYCLES = 40;
   localparam int         RANDOM_ITEMS  = 330;
   localparam int         CYCLE_LIMIT   = 400000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_action = ACT_LOAD;
   addr_type             req_entry_index = '0;
   value_type            req_entry_value = '0;
   value_type            req_search_key = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_found;
   addr_type             rsp_position;
   len_type              rsp_final_lower;
   logic signed [5:0]    rsp_final_upper;
   logic                 csr_wr_en = 1'b0;
   len_type              csr_wr_data = '0;

   int        error_count;
   int        pending_count;
   int        checked_count;
   int        cycle_count = 0;
   bit        no_gaps = 1'b0;
   bit        hold_off = 1'b0;
   value_type loaded_values [TABLE_DEPTH];
   int        load_count = 0;
   int        linear_count = 0;
   int        binary_count = 0;
   int        ignored_count = 0;
   int        random_items = 0;
   int        phase_count = 0;

   always #2 clock = ~clock;

   sorted_table_search dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_final_lower (rsp_final_lower),
      .rsp_final_upper (rsp_final_upper),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   sorted_table_search_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_final_lower (rsp_final_lower),
      .rsp_final_upper (rsp_final_upper),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offer one transaction after a random gap and hold it until accepted.
   task automatic send_item(logic [1:0] act, addr_type idx, value_type val, value_type key);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_entry_index <= idx;
      req_entry_value <= val;
      req_search_key  <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (act)
         ACT_LOAD:   load_count++;
         ACT_LINEAR: linear_count++;
         ACT_BINARY: binary_count++;
         default:    ignored_count++;
      endcase
   endtask

   task automatic do_load(int idx, value_type val);
      loaded_values[idx] = val;
      send_item(ACT_LOAD, addr_type'(idx), val, value_type'($urandom));
   endtask

   task automatic do_search(logic [1:0] act, value_type key);
      send_item(act, addr_type'($urandom), value_type'($urandom), key);
   endtask

   // Drop valid, wait for every result, then let a trailing load settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(int len);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len_type'(len);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Load entries 0..count-1 in non-decreasing signed order.
   task automatic load_sorted(int count, int style);
      longint cur;
      longint step_max;
      int i;
      case (style)
         0: begin
            cur = -64'sd2147483648;
            step_max = 64'd134217728;
         end
         1: begin
            cur = -longint'($urandom_range(0, 10));
            step_max = 2;
         end
         default: begin
            cur = -64'sd2147483648 + longint'($urandom_range(0, 32'h7FFF_FFFF));
            step_max = longint'($urandom_range(1, 32'h0400_0000));
         end
      endcase
      for (i = 0; i < count; i++) begin
         if (i > 0) cur += longint'($urandom_range(0, 32'(step_max)));
         if (cur > 64'sd2147483647) cur = 64'sd2147483647;
         if (style == 0 && i == count - 1) cur = 64'sd2147483647;
         do_load(i, value_type'(cur[31:0]));
      end
   endtask

   function automatic value_type pick_key(int n);
      int r;
      r = $urandom_range(0, 9);
      if (n > 0 && r < 6) return loaded_values[$urandom_range(0, n - 1)];
      if (n > 0 && r < 8) begin
         return loaded_values[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      end
      if (r == 8) return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
      return value_type'($urandom);
   endfunction

   task automatic run_phase();
      int len;
      int n;
      int searches;
      int r;
      int i;
      drain();
      case (phase_count)
         0: len = 32;
         1: len = 63;
         2: len = 1;
         3: len = 0;
         4: len = 40;
         default: begin
            r = $urandom_range(0, 9);
            len = (r == 0) ? 0 : (r == 1) ? 2 : (r == 2) ? 32 : (r == 3) ? 63 :
                  $urandom_range(3, 31);
         end
      endcase
      write_length(len);
      n = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
      no_gaps = ($urandom_range(0, 3) == 0);
      if (phase_count > 0 && $urandom_range(0, 2) != 0) begin
         r = ($urandom_range(0, 3) == 0) ? TABLE_DEPTH : n;
         load_sorted(r, $urandom_range(0, 2));
         random_items += r;
      end
      // Back up the result channel so the block fills and stalls its input.
      if (phase_count == 0) hold_off = 1'b1;
      searches = $urandom_range(15, 30);
      for (i = 0; i < searches; i++) begin
         r = $urandom_range(0, 19);
         if (r == 0) begin
            send_item(ACT_UNUSED, addr_type'($urandom), value_type'($urandom),
                      value_type'($urandom));
         end else begin
            if (r == 1) do_load($urandom_range(0, TABLE_DEPTH - 1), value_type'($urandom));
            else do_search($urandom_range(0, 1) ? ACT_LINEAR : ACT_BINARY, pick_key(n));
            random_items++;
         end
      end
      phase_count++;
   endtask

   // Result side: random stall before each transaction, plus one long hold-off.
   initial begin : result_sink
      int hold;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end
         hold = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table after reset, and an action the block ignores.
      do_search(ACT_LINEAR, 32'sd0);
      do_search(ACT_BINARY, 32'sd0);
      send_item(ACT_UNUSED, addr_type'($urandom), value_type'($urandom),
                value_type'($urandom));
      do_load(0, VALUE_MIN);
      do_load(1, -32'sd5);
      do_load(2, 32'sd7);
      do_load(3, VALUE_MAX);
      drain();
      write_length(4);
      do_search(ACT_LINEAR, VALUE_MIN);
      do_search(ACT_LINEAR, VALUE_MAX);
      do_search(ACT_LINEAR, 32'sd0);
      do_search(ACT_BINARY, VALUE_MIN);
      do_search(ACT_BINARY, VALUE_MAX);
      do_search(ACT_BINARY, 32'sd7);
      do_search(ACT_BINARY, -32'sd5);
      do_search(ACT_BINARY, 32'sd0);
      do_search(ACT_BINARY, 32'sd8);
      // Break the ordering; binary search must still follow its probe rule.
      do_load(1, 32'sd100);
      do_search(ACT_BINARY, 32'sd7);
      do_search(ACT_LINEAR, 32'sd100);

      // Every entry is written before any longer length is set.
      load_sorted(TABLE_DEPTH, 0);
      while (random_items < RANDOM_ITEMS) run_phase();
      drain();

      $display("Covered %0d loads, %0d linear and %0d binary searches, %0d ignored actions",
               load_count, linear_count, binary_count, ignored_count);
      $display("over %0d table length settings; %0d results compared in %0d cycles",
               phase_count + 1, checked_count, cycle_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
rtl/sts_pkg.sv
rtl/sorted_table_search.sv
bench/sorted_table_search_checker.sv
bench/sorted_table_search_tb.sv
